/* sv/oldp_pkg.sv */
// shared types, constants and pulse mapping for the obstacle limited drive pwm
`timescale 1ns / 1ps

package oldp_pkg;

  localparam int PULSE_BITS = 12;
  localparam int Q_ONE      = 16384;
  localparam int CFG_BITS   = 15;
  localparam int LIM_BITS   = 15;
  localparam int N_SENSORS  = 6;

  // sensor slots in the limit vector
  localparam int SEN_FRONT       = 0;
  localparam int SEN_RIGHT_FRONT = 1;
  localparam int SEN_LEFT_FRONT  = 2;
  localparam int SEN_BACK        = 3;
  localparam int SEN_RIGHT_BACK  = 4;
  localparam int SEN_LEFT_BACK   = 5;

  localparam logic [PULSE_BITS-1:0] RST_FWD_PULSE_LOW   = 12'd1323;
  localparam logic [PULSE_BITS-1:0] RST_FWD_PULSE_HIGH  = 12'd1620;
  localparam logic [PULSE_BITS-1:0] RST_TURN_PULSE_LOW  = 12'd1193;
  localparam logic [PULSE_BITS-1:0] RST_TURN_PULSE_HIGH = 12'd2121;
  localparam logic [PULSE_BITS-1:0] RST_NEUTRAL_PULSE   = 12'd544;
  localparam logic [5:0]            RST_IDLE_LIMIT      = 6'd30;
  localparam logic [14:0]           RST_TURN_THRESHOLD  = 15'd4915;
  localparam logic [14:0]           RST_DEADBAND        = 15'd819;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    REG_FWD_PULSE_LOW   = 3'd0,
    REG_FWD_PULSE_HIGH  = 3'd1,
    REG_TURN_PULSE_LOW  = 3'd2,
    REG_TURN_PULSE_HIGH = 3'd3,
    REG_NEUTRAL_PULSE   = 3'd4,
    REG_IDLE_LIMIT      = 3'd5,
    REG_TURN_THRESHOLD  = 3'd6,
    REG_DEADBAND        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PULSE_BITS-1:0] fwd_pulse_low;
    logic [PULSE_BITS-1:0] fwd_pulse_high;
    logic [PULSE_BITS-1:0] turn_pulse_low;
    logic [PULSE_BITS-1:0] turn_pulse_high;
    logic [PULSE_BITS-1:0] neutral_pulse;
    logic [5:0]            idle_limit;
    logic [14:0]           turn_threshold;
    logic [14:0]           deadband;
  } cfg_t;

  typedef struct packed {
    kind_e                               kind;
    logic signed [15:0]                  fwd;
    logic signed [15:0]                  turn;
    logic [N_SENSORS-1:0][LIM_BITS-1:0]  lim;
  } stage_t;

  typedef struct packed {
    logic                  drive_enabled;
    logic [PULSE_BITS-1:0] throttle_pulse;
    logic [PULSE_BITS-1:0] steering_pulse;
    logic                  timed_out;
  } result_t;

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
    logic signed [15:0] res;
    if (v > 16'sd16384) begin
      res = 16'sd16384;
    end else if (v < -16'sd16384) begin
      res = -16'sd16384;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // linear map of a q2.14 target onto [lo, hi], truncating
  function automatic logic [PULSE_BITS-1:0] map_pulse(
    input logic [PULSE_BITS-1:0] lo,
    input logic [PULSE_BITS-1:0] hi,
    input logic signed [15:0]    target
  );
    logic signed [16:0]            u;
    logic signed [PULSE_BITS:0]    diff;
    logic signed [PULSE_BITS+17:0] prod;
    logic signed [PULSE_BITS+17:0] total;
    u     = {target[15], target} + 17'sd16384;
    diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod  = diff * u;
    total = prod + $signed({3'b000, lo, 15'b0});
    return total[15 +: PULSE_BITS];
  endfunction

endpackage

/* sv/oldp_ifs.sv */
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface oldp_item_if;
  import oldp_pkg::*;
  logic               valid;
  logic               ready;
  logic [0:0]         kind;
  logic signed [15:0] forward_cmd;
  logic signed [15:0] turn_cmd;
  logic [15:0]        dist_front;
  logic [15:0]        dist_right_front;
  logic [15:0]        dist_left_front;
  logic [15:0]        dist_back;
  logic [15:0]        dist_right_back;
  logic [15:0]        dist_left_back;

  modport source (
    output valid, kind, forward_cmd, turn_cmd, dist_front, dist_right_front,
           dist_left_front, dist_back, dist_right_back, dist_left_back,
    input  ready
  );
  modport sink (
    input  valid, kind, forward_cmd, turn_cmd, dist_front, dist_right_front,
           dist_left_front, dist_back, dist_right_back, dist_left_back,
    output ready
  );
endinterface

interface oldp_result_if;
  import oldp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  drive_enabled;
  logic [PULSE_BITS-1:0] throttle_pulse;
  logic [PULSE_BITS-1:0] steering_pulse;
  logic                  timed_out;

  modport source (
    output valid, drive_enabled, throttle_pulse, steering_pulse, timed_out,
    input  ready
  );
  modport sink (
    input  valid, drive_enabled, throttle_pulse, steering_pulse, timed_out,
    output ready
  );
endinterface

/* sv/oldp_dist_limit.sv */
// distance to q2.14 speed limit, floor(dist * 16384 / full speed) by reciprocal
`timescale 1ns / 1ps

module oldp_dist_limit #(
  parameter int unsigned FULL_SPEED_MM = 1000
) (
  input  logic [15:0]                   range_mm,
  output logic [oldp_pkg::LIM_BITS-1:0] lim
);
  import oldp_pkg::*;

  localparam int unsigned     SH      = $clog2(FULL_SPEED_MM);
  localparam longint unsigned RECIP_W =
    ((64'd1 << (30 + SH)) + FULL_SPEED_MM - 1) / FULL_SPEED_MM;
  localparam logic [31:0]     RECIP   = RECIP_W[31:0];

  logic [47:0] prod;
  logic [47:0] quo;

  always_comb begin
    prod = {32'b0, range_mm} * {16'b0, RECIP};
    quo  = prod >> (16 + SH);
    // anything past full scale can never bind
    if (quo >= 48'(Q_ONE)) begin
      lim = LIM_BITS'(Q_ONE);
    end else begin
      lim = quo[LIM_BITS-1:0];
    end
  end

endmodule

/* sv/oldp_core.sv */
// drive state, sector choice, speed clamp, pulse mapping and idle stop
`timescale 1ns / 1ps

module oldp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  oldp_pkg::cfg_t    cfg,
  input  oldp_pkg::stage_t  word,
  output oldp_pkg::result_t res
);
  import oldp_pkg::*;

  logic signed [15:0]    target_forward, target_forward_next;
  logic signed [15:0]    target_turn, target_turn_next;
  logic                  running, running_next;
  logic [5:0]            idle_count, idle_count_next;
  logic [PULSE_BITS-1:0] throttle_reg, throttle_reg_next;
  logic [PULSE_BITS-1:0] steering_reg, steering_reg_next;

  logic signed [16:0]    tt17, tf17, thr17, lf17, lb17;
  logic                  go_right, go_left;
  logic [LIM_BITS-1:0]   lim_front, lim_back;
  logic signed [15:0]    tf_cl;
  logic [PULSE_BITS-1:0] pf, pt;
  logic                  timeout;
  logic [14:0]           af;
  logic [PULSE_BITS-1:0] throttle_tick;

  // tick datapath
  always_comb begin
    tt17     = {target_turn[15], target_turn};
    tf17     = {target_forward[15], target_forward};
    thr17    = $signed({2'b00, cfg.turn_threshold});
    go_right = tt17 > thr17;
    go_left  = tt17 < -thr17;

    priority if (go_right) begin
      lim_front = word.lim[SEN_RIGHT_FRONT];
      lim_back  = word.lim[SEN_RIGHT_BACK];
    end else if (go_left) begin
      lim_front = word.lim[SEN_LEFT_FRONT];
      lim_back  = word.lim[SEN_LEFT_BACK];
    end else begin
      lim_front = word.lim[SEN_FRONT];
      lim_back  = word.lim[SEN_BACK];
    end

    lf17 = $signed({2'b00, lim_front});
    lb17 = $signed({2'b00, lim_back});
    if (target_forward > 16'sd0) begin
      tf_cl = (tf17 > lf17) ? lf17[15:0] : target_forward;
    end else begin
      tf_cl = (tf17 < -lb17) ? 16'(-lb17) : target_forward;
    end

    pf      = map_pulse(cfg.fwd_pulse_low, cfg.fwd_pulse_high, tf_cl);
    pt      = map_pulse(cfg.turn_pulse_low, cfg.turn_pulse_high, target_turn);
    timeout = idle_count > cfg.idle_limit;

    // a stop drops the forward target to zero before the deadband test
    if (timeout) begin
      af = 15'd0;
    end else if (tf_cl[15]) begin
      af = 15'(-tf_cl);
    end else begin
      af = tf_cl[14:0];
    end
    throttle_tick = (af < cfg.deadband) ? cfg.neutral_pulse : pf;
  end

  // next state
  always_comb begin
    running_next        = running;
    target_forward_next = target_forward;
    target_turn_next    = target_turn;
    idle_count_next     = idle_count;
    throttle_reg_next   = throttle_reg;
    steering_reg_next   = steering_reg;
    unique case (word.kind)
      KIND_CMD: begin
        running_next        = 1'b1;
        target_forward_next = word.fwd;
        target_turn_next    = word.turn;
        idle_count_next     = 6'd0;
        if (!running) begin
          throttle_reg_next = '0;
          steering_reg_next = '0;
        end
      end
      KIND_TICK: begin
        if (timeout) begin
          running_next        = 1'b0;
          target_forward_next = '0;
          target_turn_next    = '0;
        end else begin
          target_forward_next = tf_cl;
        end
        idle_count_next   = (&idle_count) ? idle_count : idle_count + 6'd1;
        throttle_reg_next = throttle_tick;
        steering_reg_next = pt;
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    res.drive_enabled  = running_next;
    res.throttle_pulse = throttle_reg_next;
    res.steering_pulse = steering_reg_next;
    res.timed_out      = (word.kind == KIND_TICK) && timeout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      target_forward <= '0;
      target_turn    <= '0;
      idle_count     <= '0;
      throttle_reg   <= '0;
      steering_reg   <= '0;
    end else if (en) begin
      running        <= running_next;
      target_forward <= target_forward_next;
      target_turn    <= target_turn_next;
      idle_count     <= idle_count_next;
      throttle_reg   <= throttle_reg_next;
      steering_reg   <= steering_reg_next;
    end
  end

endmodule

/* sv/obstacle_limited_drive_pwm.sv */
// top level: config registers, input stage, drive core and result register
//
//   port     dir   handshake     word
//   item     in    valid/ready   kind, commands, six distances
//   result   out   valid/ready   drive_enabled, pulses, timed_out
//   cfg      in    cfg_write_en  cfg_index, cfg_data
//
// one word per cycle while results are taken; a taken word moves from the
// input register through the single core stage into the result register once
// that is free; while a result waits, the input register takes a word only if
// empty; rst (synchronous) clears the drive state and loads the config defaults
`timescale 1ns / 1ps

module obstacle_limited_drive_pwm #(
  parameter int unsigned FULL_SPEED_MM = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  oldp_item_if.sink                     item,
  oldp_result_if.source                 result,
  input  logic                          cfg_write_en,
  input  logic [2:0]                    cfg_index,
  input  logic [oldp_pkg::CFG_BITS-1:0] cfg_data
);
  import oldp_pkg::*;

  cfg_t    cfg;
  stage_t  s1;
  logic    s1_valid;
  result_t res;
  logic    res_valid;
  result_t core_res;
  logic    res_free;
  logic    s1_go;

  logic [N_SENSORS-1:0][15:0]       dists;
  logic [N_SENSORS-1:0][LIM_BITS-1:0] lims;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_pulse_low   <= RST_FWD_PULSE_LOW;
      cfg.fwd_pulse_high  <= RST_FWD_PULSE_HIGH;
      cfg.turn_pulse_low  <= RST_TURN_PULSE_LOW;
      cfg.turn_pulse_high <= RST_TURN_PULSE_HIGH;
      cfg.neutral_pulse   <= RST_NEUTRAL_PULSE;
      cfg.idle_limit      <= RST_IDLE_LIMIT;
      cfg.turn_threshold  <= RST_TURN_THRESHOLD;
      cfg.deadband        <= RST_DEADBAND;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_FWD_PULSE_LOW:   cfg.fwd_pulse_low   <= cfg_data[PULSE_BITS-1:0];
        REG_FWD_PULSE_HIGH:  cfg.fwd_pulse_high  <= cfg_data[PULSE_BITS-1:0];
        REG_TURN_PULSE_LOW:  cfg.turn_pulse_low  <= cfg_data[PULSE_BITS-1:0];
        REG_TURN_PULSE_HIGH: cfg.turn_pulse_high <= cfg_data[PULSE_BITS-1:0];
        REG_NEUTRAL_PULSE:   cfg.neutral_pulse   <= cfg_data[PULSE_BITS-1:0];
        REG_IDLE_LIMIT:      cfg.idle_limit      <= cfg_data[5:0];
        REG_TURN_THRESHOLD:  cfg.turn_threshold  <= cfg_data[14:0];
        REG_DEADBAND:        cfg.deadband        <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // speed limits for every sensor, ahead of the input register
  always_comb begin
    dists[SEN_FRONT]       = item.dist_front;
    dists[SEN_RIGHT_FRONT] = item.dist_right_front;
    dists[SEN_LEFT_FRONT]  = item.dist_left_front;
    dists[SEN_BACK]        = item.dist_back;
    dists[SEN_RIGHT_BACK]  = item.dist_right_back;
    dists[SEN_LEFT_BACK]   = item.dist_left_back;
  end

  for (genvar g = 0; g < N_SENSORS; g++) begin : g_lim
    oldp_dist_limit #(
      .FULL_SPEED_MM(FULL_SPEED_MM)
    ) u_lim (
      .range_mm(dists[g]),
      .lim     (lims[g])
    );
  end

  assign res_free   = !res_valid || result.ready;
  assign s1_go      = s1_valid && res_free;
  assign item.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1.kind <= kind_e'(item.kind);
      s1.fwd  <= clamp_q(item.forward_cmd);
      s1.turn <= clamp_q(item.turn_cmd);
      s1.lim  <= lims;
    end
  end

  oldp_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (s1_go),
    .cfg (cfg),
    .word(s1),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res <= core_res;
    end
  end

  assign result.valid          = res_valid;
  assign result.drive_enabled  = res.drive_enabled;
  assign result.throttle_pulse = res.throttle_pulse;
  assign result.steering_pulse = res.steering_pulse;
  assign result.timed_out      = res.timed_out;

endmodule

/* tb/sv/tb_top.sv */
// testbench for obstacle_limited_drive_pwm: random commands and ticks checked by a scoreboard
`timescale 1ns / 1ps

module tb_top;
  import oldp_pkg::*;

  localparam int unsigned FULL_SPEED_MM = 1000;
  localparam longint      TIMEOUT_NS    = 64'd3_000_000;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
    logic [15:0]        d_front;
    logic [15:0]        d_right_front;
    logic [15:0]        d_left_front;
    logic [15:0]        d_back;
    logic [15:0]        d_right_back;
    logic [15:0]        d_left_back;
  } in_word_t;

  class drive_scoreboard;
    cfg_t                  regs;
    int                    fwd_tgt;
    int                    turn_tgt;
    bit                    running;
    int unsigned           idle_cnt;
    logic [PULSE_BITS-1:0] throttle_q;
    logic [PULSE_BITS-1:0] steering_q;
    result_t               pending[$];
    int                    errors;
    int                    n_checked;

    function new();
      regs.fwd_pulse_low   = RST_FWD_PULSE_LOW;
      regs.fwd_pulse_high  = RST_FWD_PULSE_HIGH;
      regs.turn_pulse_low  = RST_TURN_PULSE_LOW;
      regs.turn_pulse_high = RST_TURN_PULSE_HIGH;
      regs.neutral_pulse   = RST_NEUTRAL_PULSE;
      regs.idle_limit      = RST_IDLE_LIMIT;
      regs.turn_threshold  = RST_TURN_THRESHOLD;
      regs.deadband        = RST_DEADBAND;
      stop_drive();
      idle_cnt  = 0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function void stop_drive();
      running    = 1'b0;
      fwd_tgt    = 0;
      turn_tgt   = 0;
      throttle_q = '0;
      steering_q = '0;
    endfunction

    function int sat_q14(logic signed [15:0] v);
      int x;
      x = v;
      if (x > Q_ONE) x = Q_ONE;
      if (x < -Q_ONE) x = -Q_ONE;
      return x;
    endfunction

    function int speed_cap(logic [15:0] mm);
      longint wide;
      wide = mm;
      return int'((wide * Q_ONE) / FULL_SPEED_MM);
    endfunction

    function logic [PULSE_BITS-1:0] scale_pulse(logic [PULSE_BITS-1:0] lo,
                                                 logic [PULSE_BITS-1:0] hi, int tgt);
      longint lo_w;
      longint hi_w;
      longint total;
      lo_w  = lo;
      hi_w  = hi;
      total = lo_w * 32768 + (hi_w - lo_w) * (tgt + Q_ONE);
      if (total < 0) total = 0;
      return PULSE_BITS'(total >> 15);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_FWD_PULSE_LOW:   regs.fwd_pulse_low   = val[PULSE_BITS-1:0];
        REG_FWD_PULSE_HIGH:  regs.fwd_pulse_high  = val[PULSE_BITS-1:0];
        REG_TURN_PULSE_LOW:  regs.turn_pulse_low  = val[PULSE_BITS-1:0];
        REG_TURN_PULSE_HIGH: regs.turn_pulse_high = val[PULSE_BITS-1:0];
        REG_NEUTRAL_PULSE:   regs.neutral_pulse   = val[PULSE_BITS-1:0];
        REG_IDLE_LIMIT:      regs.idle_limit      = val[5:0];
        REG_TURN_THRESHOLD:  regs.turn_threshold  = val[14:0];
        REG_DEADBAND:        regs.deadband        = val[14:0];
        default: ;
      endcase
    endfunction

    function void note_word(in_word_t w);
      result_t               r;
      int                    thr;
      int                    db;
      int                    lim;
      int                    mag;
      logic [15:0]           d_ahead;
      logic [15:0]           d_behind;
      logic [PULSE_BITS-1:0] fp;
      logic [PULSE_BITS-1:0] tp;
      bit                    halted;
      halted = 1'b0;
      if (w.kind == KIND_CMD) begin
        if (!running) begin
          stop_drive();
          running = 1'b1;
        end
        fwd_tgt  = sat_q14(w.fwd);
        turn_tgt = sat_q14(w.turn);
        idle_cnt = 0;
      end else begin
        thr = regs.turn_threshold;
        db  = regs.deadband;
        if (turn_tgt > thr) begin
          d_ahead  = w.d_right_front;
          d_behind = w.d_right_back;
        end else if (turn_tgt < -thr) begin
          d_ahead  = w.d_left_front;
          d_behind = w.d_left_back;
        end else begin
          d_ahead  = w.d_front;
          d_behind = w.d_back;
        end
        if (fwd_tgt > 0) begin
          lim = speed_cap(d_ahead);
          if (fwd_tgt > lim) fwd_tgt = lim;
        end else begin
          lim = -speed_cap(d_behind);
          if (fwd_tgt < lim) fwd_tgt = lim;
        end
        fp = scale_pulse(regs.fwd_pulse_low, regs.fwd_pulse_high, fwd_tgt);
        tp = scale_pulse(regs.turn_pulse_low, regs.turn_pulse_high, turn_tgt);
        if (idle_cnt > regs.idle_limit) begin
          stop_drive();
          halted = 1'b1;
        end
        if (idle_cnt < 63) idle_cnt++;
        mag = (fwd_tgt < 0) ? -fwd_tgt : fwd_tgt;
        throttle_q = (mag < db) ? regs.neutral_pulse : fp;
        steering_q = tp;
      end
      r.drive_enabled  = running;
      r.throttle_pulse = throttle_q;
      r.steering_pulse = steering_q;
      r.timed_out      = halted;
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < 200) $display("mismatch at result %0d: %s", n_checked, msg);
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("word %h with nothing outstanding", got));
      end else begin
        want = pending.pop_front();
        if (got.drive_enabled !== want.drive_enabled)
          report_mismatch($sformatf("drive_enabled %b, want %b",
                                    got.drive_enabled, want.drive_enabled));
        if (got.throttle_pulse !== want.throttle_pulse)
          report_mismatch($sformatf("throttle_pulse %0d, want %0d",
                                    got.throttle_pulse, want.throttle_pulse));
        if (got.steering_pulse !== want.steering_pulse)
          report_mismatch($sformatf("steering_pulse %0d, want %0d",
                                    got.steering_pulse, want.steering_pulse));
        if (got.timed_out !== want.timed_out)
          report_mismatch($sformatf("timed_out %b, want %b",
                                    got.timed_out, want.timed_out));
      end
      n_checked++;
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write_en;
  logic [2:0]          cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  int                  src_idle_pct;
  int                  snk_idle_pct;

  drive_scoreboard sb = new();

  oldp_item_if   item_ch ();
  oldp_result_if result_ch ();

  obstacle_limited_drive_pwm #(
    .FULL_SPEED_MM(FULL_SPEED_MM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_items
    in_word_t w;
    if (!rst && item_ch.valid && item_ch.ready) begin
      w.kind          = kind_e'(item_ch.kind);
      w.fwd           = item_ch.forward_cmd;
      w.turn          = item_ch.turn_cmd;
      w.d_front       = item_ch.dist_front;
      w.d_right_front = item_ch.dist_right_front;
      w.d_left_front  = item_ch.dist_left_front;
      w.d_back        = item_ch.dist_back;
      w.d_right_back  = item_ch.dist_right_back;
      w.d_left_back   = item_ch.dist_left_back;
      sb.note_word(w);
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.drive_enabled  = result_ch.drive_enabled;
      got.throttle_pulse = result_ch.throttle_pulse;
      got.steering_pulse = result_ch.steering_pulse;
      got.timed_out      = result_ch.timed_out;
      sb.check_word(got);
    end
  end

  function automatic in_word_t cmd_word(logic signed [15:0] fwd, logic signed [15:0] turn);
    in_word_t w;
    w.kind          = KIND_CMD;
    w.fwd           = fwd;
    w.turn          = turn;
    w.d_front       = 16'($urandom);
    w.d_right_front = 16'($urandom);
    w.d_left_front  = 16'($urandom);
    w.d_back        = 16'($urandom);
    w.d_right_back  = 16'($urandom);
    w.d_left_back   = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t tick_word(logic [15:0] f, logic [15:0] rf, logic [15:0] lf,
                                         logic [15:0] b, logic [15:0] rb, logic [15:0] lb);
    in_word_t w;
    w.kind          = KIND_TICK;
    w.fwd           = 16'($urandom);
    w.turn          = 16'($urandom);
    w.d_front       = f;
    w.d_right_front = rf;
    w.d_left_front  = lf;
    w.d_back        = b;
    w.d_right_back  = rb;
    w.d_left_back   = lb;
    return w;
  endfunction

  // values clustered around a threshold, the clamp limits and the full range
  function automatic logic signed [15:0] rand_q(int near);
    int v;
    case ($urandom_range(4))
      0: v = int'($urandom);
      1: v = $urandom_range(1) ? Q_ONE : -Q_ONE;
      2: begin
        v = near + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) v = -v;
      end
      default: v = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
    endcase
    return 16'(v);
  endfunction

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(3))
      0: return 16'($urandom_range(1500));
      1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(300));
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid            <= 1'b1;
    item_ch.kind             <= w.kind;
    item_ch.forward_cmd      <= w.fwd;
    item_ch.turn_cmd         <= w.turn;
    item_ch.dist_front       <= w.d_front;
    item_ch.dist_right_front <= w.d_right_front;
    item_ch.dist_left_front  <= w.d_left_front;
    item_ch.dist_back        <= w.d_back;
    item_ch.dist_right_back  <= w.d_right_back;
    item_ch.dist_left_back   <= w.d_left_back;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_BITS-1:0] vals [8]);
    drain_results();
    for (int i = REG_FWD_PULSE_LOW; i <= REG_DEADBAND; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= cfg_reg_e'(i);
      cfg_data     <= vals[i];
      @(posedge clk);
      sb.write_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [CFG_BITS-1:0] vals [8];
    int                  sent;
    int                  run;
    bit                  paused;
    rst                      <= 1'b1;
    cfg_write_en             <= 1'b0;
    cfg_index                <= REG_FWD_PULSE_LOW;
    cfg_data                 <= '0;
    item_ch.valid            <= 1'b0;
    item_ch.kind             <= KIND_CMD;
    item_ch.forward_cmd      <= '0;
    item_ch.turn_cmd         <= '0;
    item_ch.dist_front       <= '0;
    item_ch.dist_right_front <= '0;
    item_ch.dist_left_front  <= '0;
    item_ch.dist_back        <= '0;
    item_ch.dist_right_back  <= '0;
    item_ch.dist_left_back   <= '0;
    src_idle_pct = 20;
    snk_idle_pct = 70;
    paused       = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // tick while stopped, then clamping, sector choice, distance limits, deadband edges
    send_word(tick_word(rand_dist(), rand_dist(), rand_dist(),
                        rand_dist(), rand_dist(), rand_dist()));
    send_word(cmd_word(16'sh7fff, 16'sh8000));
    send_word(tick_word(16'd5000, 16'd5000, 16'd0, 16'd5000, 16'd5000, 16'd5000));
    send_word(cmd_word(16'sd16384, 16'sd16384));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(-16'sd16384, 16'sd4915));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'd500, 16'hffff, 16'hffff));
    send_word(cmd_word(16'sh8000, 16'sh7fff));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'hffff));
    send_word(cmd_word(16'sd0, -16'sd4915));
    send_word(tick_word(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_word(cmd_word(16'sd819, 16'sd4916));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(16'sd818, -16'sd4916));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(-16'sd819, 16'sd0));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(16'sd16384, 16'sd0));
    send_word(tick_word(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_word(tick_word(16'd999, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));

    // idle stop with a zero limit, restart from stopped
    vals = '{CFG_BITS'(RST_FWD_PULSE_LOW), CFG_BITS'(RST_FWD_PULSE_HIGH),
             CFG_BITS'(RST_TURN_PULSE_LOW), CFG_BITS'(RST_TURN_PULSE_HIGH),
             CFG_BITS'(RST_NEUTRAL_PULSE), 15'd0, CFG_BITS'(RST_TURN_THRESHOLD),
             CFG_BITS'(RST_DEADBAND)};
    set_config(vals);
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(16'sd12000, -16'sd3000));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(tick_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(cmd_word(-16'sd12000, 16'sd3000));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: vals = '{15'd4095, 15'd4095, 15'd4095, 15'd4095, 15'd4095,
                    15'd62, 15'd16384, 15'd16384};
        1: vals = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
        2: vals = '{15'd4095, 15'd0, 15'd3000, 15'd100, 15'd1500,
                    15'd3, 15'd2000, 15'd100};
        default: begin
          for (int i = REG_FWD_PULSE_LOW; i <= REG_NEUTRAL_PULSE; i++)
            vals[i] = 15'($urandom_range(4095));
          vals[REG_IDLE_LIMIT]     = ($urandom_range(3) == 0) ? 15'd62
                                                              : 15'($urandom_range(10));
          vals[REG_TURN_THRESHOLD] = 15'($urandom_range(Q_ONE));
          vals[REG_DEADBAND]       = 15'($urandom_range(3000));
        end
      endcase
      set_config(vals);
      src_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 70 : 0;
      snk_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 20 : 0;
      sent = 0;
      while (sent < 250) begin
        if (!paused && sent >= 120) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          send_word(cmd_word(rand_q(sb.regs.deadband), rand_q(sb.regs.turn_threshold)));
          run = ($urandom_range(99) < 12) ? $urandom_range(72, sb.regs.idle_limit)
                                          : $urandom_range(6);
          repeat (run) send_word(tick_word(rand_dist(), rand_dist(), rand_dist(),
                                           rand_dist(), rand_dist(), rand_dist()));
          sent += run + 1;
        end else begin
          // stray tick word with every other field random
          send_word(tick_word(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom)));
          if ($urandom_range(1)) send_word(cmd_word(16'($urandom), 16'($urandom)));
          sent += 2;
        end
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
